@@ design/fhbs_pkg.sv @@
`timescale 1ns / 1ps

package fhbs_pkg;

   localparam int DEFAULT_TABLE_DEPTH  = 1024;
   localparam int DEFAULT_MAX_BACKENDS = 16;

   localparam int HASH_W = 32;
   localparam int POS_W  = 6;
   localparam int ETYPE_W = 16;
   localparam int BYTE_W = 8;
   localparam int ID_W = 32;

   localparam logic MODE_TABLE = 1'b0;
   localparam logic MODE_BYTE  = 1'b1;

   localparam logic [HASH_W-1:0]  HASH_SEED = 32'd5381;
   localparam logic [ETYPE_W-1:0] ETH_IPV4  = 16'h0800;
   localparam logic [ETYPE_W-1:0] ETH_IPV6  = 16'h86dd;
   localparam logic [POS_W-1:0]   V4_START  = 6'd12;
   localparam logic [POS_W:0]     V4_END    = 7'd20;
   localparam logic [POS_W-1:0]   V6_START  = 6'd8;
   localparam logic [POS_W:0]     V6_END    = 7'd40;
   localparam logic [POS_W-1:0]   POS_MAX   = 6'd63;
   localparam int TABLE_SIZE_RESET = 997;

   localparam int DIV_CNT_W = $clog2(HASH_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_DELIVER
   } fhbs_state_type;

   typedef struct packed {
      logic take;
      logic start;
      logic step;
      logic read;
      logic load;
   } fhbs_cmd_type;

endpackage

@@ design/fhbs_ram.sv @@
`timescale 1ns / 1ps

module fhbs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fhbs_ctrl.sv @@
`timescale 1ns / 1ps

module fhbs_ctrl import fhbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_mode,
   input  logic         req_byte_last,
   output logic         req_stall,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output fhbs_cmd_type cmd
);

   fhbs_state_type       state_ff, state_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take  = req_valid;
            cmd.start = req_valid && (req_mode == MODE_BYTE) && req_byte_last;
            if (cmd.start) begin
               state_in = ST_DIVIDE;
               count_in = '0;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(HASH_W - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/fhbs_datapath.sv @@
`timescale 1ns / 1ps

module fhbs_datapath import fhbs_pkg::*; #(
   parameter int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH,
   parameter int MAX_BACKENDS = DEFAULT_MAX_BACKENDS,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int TW = AW + 1,
   localparam int VW = $clog2(MAX_BACKENDS),
   localparam int MW = VW + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  fhbs_cmd_type       cmd,
   input  logic               csr_wr_en,
   input  logic [TW-1:0]      csr_wr_data,
   input  logic               req_mode,
   input  logic [AW-1:0]      req_table_index,
   input  logic [VW-1:0]      req_table_value,
   input  logic [ETYPE_W-1:0] req_ether_type,
   input  logic [BYTE_W-1:0]  req_payload_byte,
   input  logic [ID_W-1:0]    req_queue_id,
   output logic [ID_W-1:0]    rsp_verdict_id,
   output logic [MW-1:0]      rsp_mark,
   output logic               rsp_protocol_ok,
   output logic               rsp_short_packet
);

   localparam int SIZE_RESET =
      (TABLE_SIZE_RESET > TABLE_DEPTH) ? TABLE_DEPTH : TABLE_SIZE_RESET;

   logic [TW-1:0]     size_ff;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HASH_W-1:0] dividend_ff, dividend_in;
   logic [TW-1:0]     rem_ff, rem_in;
   logic [TW-1:0]     divisor_ff, divisor_in;
   logic [ID_W-1:0]   pid_ff, pid_in;
   logic              known_ff, known_in;
   logic              short_ff, short_in;
   logic [ID_W-1:0]   verdict_ff;
   logic [MW-1:0]     mark_ff;
   logic              ok_ff;
   logic              short_out_ff;

   logic              known;
   logic [POS_W-1:0]  win_lo;
   logic [POS_W:0]    win_hi;
   logic              in_win;
   logic [HASH_W-1:0] hash_upd;
   logic [TW-1:0]     eff_size;
   logic [TW:0]       shifted;
   logic              tbl_wr_en;
   logic [VW-1:0]     tbl_wr_data;
   logic [VW-1:0]     tbl_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= TW'(SIZE_RESET);
         hash_ff <= HASH_SEED;
         pos_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         hash_ff <= hash_in;
         pos_ff  <= pos_in;
      end
   end

   always_comb begin
      known  = 1'b1;
      win_lo = '0;
      win_hi = '0;
      if (req_ether_type == ETH_IPV4) begin
         win_lo = V4_START;
         win_hi = V4_END;
      end else if (req_ether_type == ETH_IPV6) begin
         win_lo = V6_START;
         win_hi = V6_END;
      end else begin
         known = 1'b0;
      end
   end

   assign in_win   = known && (pos_ff >= win_lo) && ({1'b0, pos_ff} < win_hi);
   assign hash_upd = in_win
      ? (hash_ff << 5) + hash_ff + HASH_W'(req_payload_byte)
      : hash_ff;

   always_comb begin
      if (size_ff == '0) begin
         eff_size = TW'(1);
      end else if (32'(size_ff) > 32'(TABLE_DEPTH)) begin
         eff_size = TW'(TABLE_DEPTH);
      end else begin
         eff_size = size_ff;
      end
   end

   assign shifted = {rem_ff, dividend_ff[HASH_W-1]};

   always_comb begin
      hash_in     = hash_ff;
      pos_in      = pos_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      pid_in      = pid_ff;
      known_in    = known_ff;
      short_in    = short_ff;
      if (cmd.start) begin
         dividend_in = hash_upd;
         rem_in      = '0;
         divisor_in  = eff_size;
         pid_in      = req_queue_id;
         known_in    = known;
         short_in    = known && (({1'b0, pos_ff} + 1'b1) < win_hi);
         hash_in     = HASH_SEED;
         pos_in      = '0;
      end else if (cmd.take && (req_mode == MODE_BYTE)) begin
         hash_in = hash_upd;
         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (cmd.step) begin
         dividend_in = dividend_ff << 1;
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = TW'(shifted - {1'b0, divisor_ff});
         end else begin
            rem_in = shifted[TW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      pid_ff      <= pid_in;
      known_ff    <= known_in;
      short_ff    <= short_in;
      if (cmd.load) begin
         verdict_ff   <= pid_ff;
         mark_ff      <= known_ff ? MW'(tbl_rd_data) + MW'(1) : '0;
         ok_ff        <= known_ff;
         short_out_ff <= short_ff;
      end
   end

   assign tbl_wr_en   = cmd.take && (req_mode == MODE_TABLE)
      && (32'(req_table_index) < 32'(TABLE_DEPTH));
   assign tbl_wr_data = (32'(req_table_value) >= 32'(MAX_BACKENDS))
      ? VW'(MAX_BACKENDS - 1) : req_table_value;

   fhbs_ram #(
      .WIDTH (VW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_table_index),
      .wr_data (tbl_wr_data),
      .rd_en   (cmd.read),
      .rd_addr (rem_ff[AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   assign rsp_verdict_id   = verdict_ff;
   assign rsp_mark         = mark_ff;
   assign rsp_protocol_ok  = ok_ff;
   assign rsp_short_packet = short_out_ff;

endmodule

@@ design/flow_hash_backend_select_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Moves
// req_      in         req_valid/stall    one table write or one payload byte
// rsp_      out        rsp_valid/stall    one verdict per last payload byte
// csr_      in         csr_wr_en          table size
//
// A table write or a non-final payload byte is taken without raising req_stall.
// A final byte starts a remainder loop (one quotient bit per cycle),
// then a table read; req_stall stays high through the loop, read and delivery.
// The result sits in an output register while the next packet streams in.
// If rsp_stall holds the previous result, req_stall stays high until it drains.
// Reset is synchronous; the lookup table holds no defined contents after it.

module flow_hash_backend_select_top import fhbs_pkg::*; #(
   parameter int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH,
   parameter int MAX_BACKENDS = DEFAULT_MAX_BACKENDS,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int TW = AW + 1,
   localparam int VW = $clog2(MAX_BACKENDS),
   localparam int MW = VW + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [TW-1:0]      csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [AW-1:0]      req_table_index,
   input  logic [VW-1:0]      req_table_value,
   input  logic [ETYPE_W-1:0] req_ether_type,
   input  logic [BYTE_W-1:0]  req_payload_byte,
   input  logic               req_byte_last,
   input  logic [ID_W-1:0]    req_queue_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_W-1:0]    rsp_verdict_id,
   output logic [MW-1:0]      rsp_mark,
   output logic               rsp_protocol_ok,
   output logic               rsp_short_packet
);

   fhbs_cmd_type cmd;

   fhbs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_mode      (req_mode),
      .req_byte_last (req_byte_last),
      .req_stall     (req_stall),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   fhbs_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_BACKENDS (MAX_BACKENDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_mode         (req_mode),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .req_ether_type   (req_ether_type),
      .req_payload_byte (req_payload_byte),
      .req_queue_id     (req_queue_id),
      .rsp_verdict_id   (rsp_verdict_id),
      .rsp_mark         (rsp_mark),
      .rsp_protocol_ok  (rsp_protocol_ok),
      .rsp_short_packet (rsp_short_packet)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import fhbs_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam int AW = 10;
   localparam int TW = 11;
   localparam int VW = 4;
   localparam int MW = 5;

   localparam int FILL_RANDOM = -1;

   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [TW-1:0] SIZE_PLAN [PHASES] =
      '{11'd997, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd1025, 11'd2, 11'd997};

   typedef struct packed {
      logic              mode;
      logic [AW-1:0]     table_index;
      logic [VW-1:0]     table_value;
      logic [ETYPE_W-1:0] ether_type;
      logic [BYTE_W-1:0] payload_byte;
      logic              byte_last;
      logic [ID_W-1:0]   queue_id;
   } req_item_t;

   typedef struct packed {
      logic [ID_W-1:0] verdict_id;
      logic [MW-1:0]   mark;
      logic            protocol_ok;
      logic            short_packet;
   } verdict_t;

   typedef struct packed {
      logic              mode;
      logic [AW-1:0]     idx;
      logic [VW-1:0]     val;
      logic [ETYPE_W-1:0] etype;
      int                count;
      int                fill;
      logic              last;
      logic [ID_W-1:0]   pid;
      logic              typed;
      logic [MW-1:0]     mark;
      logic              ok;
      logic              short_pkt;
   } dir_row_t;

   // Segments of payload bytes or single table writes; a packet may span rows.
   dir_row_t dir_rows [18] = '{
      '{MODE_TABLE, 10'd0,    4'd15, 16'h0000, 0,  0,           1'b0, 32'h0, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_TABLE, 10'd1023, 4'd0,  16'h0000, 0,  0,           1'b0, 32'h0, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, 16'h0000, 1,  8'h00,       1'b1, 32'h0000_0000, 1'b1, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, 16'hffff, 3,  8'hff,       1'b1, 32'hffff_ffff, 1'b1, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV4, 1,  8'h00,       1'b1, 32'h1, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV4, 20, 8'hff,       1'b1, 32'h2, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV4, 19, FILL_RANDOM, 1'b1, 32'h3, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV4, 70, FILL_RANDOM, 1'b1, 32'h4, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV6, 40, 8'h00,       1'b1, 32'h5, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV6, 39, 8'hff,       1'b1, 32'h6, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV6, 10, FILL_RANDOM, 1'b0, 32'h7, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_TABLE, 10'd512,  4'd10, 16'h0000, 0,  0,           1'b0, 32'h0, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV6, 30, FILL_RANDOM, 1'b1, 32'h7, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV4, 16, FILL_RANDOM, 1'b0, 32'h8, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, 16'h0801, 1,  FILL_RANDOM, 1'b1, 32'h8, 1'b1, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, 16'h86de, 12, FILL_RANDOM, 1'b0, 32'h9, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV6, 1,  FILL_RANDOM, 1'b1, 32'h9, 1'b0, 5'd0, 1'b0, 1'b0},
      '{MODE_BYTE,  10'd0, 4'd0, ETH_IPV4, 25, FILL_RANDOM, 1'b1, 32'h8000_0000,
        1'b0, 5'd0, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [TW-1:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   logic req_mode;
   logic [AW-1:0] req_table_index;
   logic [VW-1:0] req_table_value;
   logic [ETYPE_W-1:0] req_ether_type;
   logic [BYTE_W-1:0] req_payload_byte;
   logic req_byte_last;
   logic [ID_W-1:0] req_queue_id;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ID_W-1:0] rsp_verdict_id;
   logic [MW-1:0] rsp_mark;
   logic rsp_protocol_ok;
   logic rsp_short_packet;

   logic [HASH_W-1:0] hash_acc;
   int byte_pos;
   logic [TW-1:0] slot_count;
   logic [VW-1:0] backend_table [TABLE_DEPTH];
   verdict_t pending_verdicts [$];

   int send_idle_pct;
   int recv_idle_pct;
   logic hold_req = 1'b0;
   int hold_count = 0;
   int n_items = 0;
   int n_verdicts = 0;
   int n_short = 0;
   int n_unknown = 0;
   int n_errors = 0;

   flow_hash_backend_select_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .req_ether_type   (req_ether_type),
      .req_payload_byte (req_payload_byte),
      .req_byte_last    (req_byte_last),
      .req_queue_id     (req_queue_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict_id   (rsp_verdict_id),
      .rsp_mark         (rsp_mark),
      .rsp_protocol_ok  (rsp_protocol_ok),
      .rsp_short_packet (rsp_short_packet)
   );

   always #4 clock = ~clock;

   function automatic bit select_backend(input req_item_t it, output verdict_t v);
      logic known;
      int win_lo;
      int win_hi;
      int at;
      int unsigned divisor;
      v = '0;
      if (it.mode == MODE_TABLE) begin
         backend_table[it.table_index] = it.table_value;
         return 1'b0;
      end
      known = 1'b1;
      win_lo = 0;
      win_hi = 0;
      if (it.ether_type == ETH_IPV4) begin
         win_lo = int'(V4_START);
         win_hi = int'(V4_END);
      end else if (it.ether_type == ETH_IPV6) begin
         win_lo = int'(V6_START);
         win_hi = int'(V6_END);
      end else begin
         known = 1'b0;
      end
      at = byte_pos;
      if (known && at >= win_lo && at < win_hi) begin
         hash_acc = hash_acc * 32'd33 + {24'd0, it.payload_byte};
      end
      if (byte_pos < POS_MAX) begin
         byte_pos++;
      end
      if (!it.byte_last) begin
         return 1'b0;
      end
      v.verdict_id = it.queue_id;
      if (known) begin
         divisor = (slot_count == 0) ? 1 :
                   (slot_count > TABLE_DEPTH) ? TABLE_DEPTH : slot_count;
         v.mark = {1'b0, backend_table[AW'(hash_acc % divisor)]} + 5'd1;
         v.protocol_ok = 1'b1;
         v.short_packet = (at + 1 < win_hi);
         if (v.short_packet) begin
            n_short++;
         end
      end else begin
         n_unknown++;
      end
      hash_acc = HASH_SEED;
      byte_pos = 0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      n_errors++;
   endtask

   task automatic check_verdict();
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
         report_mismatch("verdict with nothing pending", rsp_verdict_id, 32'd0);
         return;
      end
      want = pending_verdicts.pop_front();
      n_verdicts++;
      if (rsp_verdict_id !== want.verdict_id) begin
         report_mismatch("verdict_id", rsp_verdict_id, want.verdict_id);
      end
      if (rsp_mark !== want.mark) begin
         report_mismatch("mark", 32'(rsp_mark), 32'(want.mark));
      end
      if (rsp_protocol_ok !== want.protocol_ok) begin
         report_mismatch("protocol_ok", 32'(rsp_protocol_ok), 32'(want.protocol_ok));
      end
      if (rsp_short_packet !== want.short_packet) begin
         report_mismatch("short_packet", 32'(rsp_short_packet), 32'(want.short_packet));
      end
   endtask

   // Offer one transaction and wait until it is accepted.
   task automatic offer(input req_item_t it, input bit typed, input verdict_t typed_v);
      verdict_t v;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_table_index <= it.table_index;
      req_table_value <= it.table_value;
      req_ether_type <= it.ether_type;
      req_payload_byte <= it.payload_byte;
      req_byte_last <= it.byte_last;
      req_queue_id <= it.queue_id;
      do @(posedge clock); while (req_stall);
      n_items++;
      if (select_backend(it, v)) begin
         pending_verdicts.push_back(typed ? typed_v : v);
      end
   endtask

   task automatic offer_table_write(input logic [AW-1:0] idx, input logic [VW-1:0] val);
      offer('{MODE_TABLE, idx, val, 16'($urandom), 8'($urandom), 1'($urandom), $urandom},
            1'b0, '0);
   endtask

   task automatic random_packet();
      logic [ETYPE_W-1:0] etype;
      logic [ETYPE_W-1:0] byte_etype;
      logic [ID_W-1:0] pid;
      int win_end;
      int len;
      int pick;
      pick = $urandom_range(9, 0);
      if (pick < 4) begin
         etype = ETH_IPV4;
         win_end = int'(V4_END);
      end else if (pick < 8) begin
         etype = ETH_IPV6;
         win_end = int'(V6_END);
      end else begin
         etype = 16'($urandom);
         win_end = 8;
      end
      pick = $urandom_range(9, 0);
      if (pick < 6) begin
         len = win_end + $urandom_range(12, 0);
      end else if (pick < 9) begin
         len = $urandom_range(win_end - 1, 1);
      end else begin
         len = $urandom_range(80, 60);
      end
      pid = $urandom;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(24, 0) == 0) begin
            offer_table_write(10'($urandom), 4'($urandom));
         end
         byte_etype = ($urandom_range(19, 0) == 0) ? 16'($urandom) : etype;
         offer('{MODE_BYTE, 10'($urandom), 4'($urandom), byte_etype, 8'($urandom),
                 i == len - 1, pid}, 1'b0, '0);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_verdict();
      end
      if (hold_req && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d verdicts still pending.", pending_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [BYTE_W-1:0] pbyte;
      logic last;
      logic [TW-1:0] size;
      int mark_start;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_mode <= MODE_BYTE;
      req_table_index <= '0;
      req_table_value <= '0;
      req_ether_type <= '0;
      req_payload_byte <= '0;
      req_byte_last <= 1'b0;
      req_queue_id <= '0;
      hash_acc = HASH_SEED;
      byte_pos = 0;
      slot_count = TW'(TABLE_SIZE_RESET);
      send_idle_pct = 21;
      recv_idle_pct = 63;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         offer_table_write(AW'(i), 4'($urandom));
      end

      foreach (dir_rows[r]) begin
         if (dir_rows[r].mode == MODE_TABLE) begin
            offer_table_write(dir_rows[r].idx, dir_rows[r].val);
         end else begin
            for (int i = 0; i < dir_rows[r].count; i++) begin
               pbyte = (dir_rows[r].fill == FILL_RANDOM) ? 8'($urandom)
                                                         : 8'(dir_rows[r].fill);
               last = dir_rows[r].last && (i == dir_rows[r].count - 1);
               offer('{MODE_BYTE, 10'($urandom), 4'($urandom), dir_rows[r].etype, pbyte,
                       last, dir_rows[r].pid},
                     dir_rows[r].typed && last,
                     '{dir_rows[r].pid, dir_rows[r].mark, dir_rows[r].ok,
                       dir_rows[r].short_pkt});
            end
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         size = (p == PHASES - 1) ? TW'($urandom_range(2047, 1)) : SIZE_PLAN[p];
         csr_wr_en <= 1'b1;
         csr_wr_data <= size;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         slot_count = size;
         if (p < 3) begin
            send_idle_pct = 21;
            recv_idle_pct = 63;
         end else if (p < 6) begin
            send_idle_pct = 63;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 1) begin
            hold_req = 1'b1;
         end
         mark_start = n_items;
         while (n_items - mark_start < ITEMS_PER_PHASE) begin
            random_packet();
         end
      end

      settle();
      $display("Accepted %0d transactions over %0d table sizes; checked %0d verdicts.",
               n_items, PHASES + 1, n_verdicts);
      $display("Verdicts included %0d short packets and %0d unsupported protocols.",
               n_short, n_unknown);
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
